### hdl/assert_macros.svh
// Assertion macros used by the top level of the command register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/scr_pkg.sv
// Types and opcode constants of the spectrometer command register block.
`default_nettype none

package scr_pkg;

   localparam int DATA_W  = 24;
   localparam int VALUE_W = 16;
   localparam int SETPT_W = 12;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Write opcodes.
   localparam logic [7:0] OP_WR_INTEG_TIME  = 8'hB2;
   localparam logic [7:0] OP_WR_GAIN_EVEN   = 8'hB7;
   localparam logic [7:0] OP_WR_GAIN_ODD    = 8'h9D;
   localparam logic [7:0] OP_WR_OFFSET_EVEN = 8'hB6;
   localparam logic [7:0] OP_WR_OFFSET_ODD  = 8'h9C;
   localparam logic [7:0] OP_WR_COOLER_ON   = 8'hD6;
   localparam logic [7:0] OP_WR_COOLER_SETP = 8'hD8;
   localparam logic [7:0] OP_WR_LASER_ON    = 8'hBE;
   localparam logic [7:0] OP_WR_HIGH_GAIN   = 8'hEB;
   localparam logic [7:0] OP_WR_ACQUIRE     = 8'hAD;

   // Read opcodes.
   localparam logic [7:0] OP_RD_INTEG_TIME  = 8'hBF;
   localparam logic [7:0] OP_RD_GAIN_EVEN   = 8'hC5;
   localparam logic [7:0] OP_RD_GAIN_ODD    = 8'h9F;
   localparam logic [7:0] OP_RD_OFFSET_EVEN = 8'hC4;
   localparam logic [7:0] OP_RD_OFFSET_ODD  = 8'h9E;
   localparam logic [7:0] OP_RD_COOLER_ON   = 8'hDA;
   localparam logic [7:0] OP_RD_LASER_ON    = 8'hE2;
   localparam logic [7:0] OP_RD_HIGH_GAIN   = 8'hEC;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODEL_INGAAS    = 2'd0;
   localparam logic [1:0] CSR_COOLING_PRESENT = 2'd1;
   localparam logic [1:0] CSR_LASER_PRESENT   = 2'd2;

   localparam logic [VALUE_W-1:0] GAIN_RESET = 16'h0100;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_UNKNOWN     = 2'd1,
      ST_UNSUPPORTED = 2'd2
   } status_type;

   typedef struct packed {
      logic model_ingaas;
      logic cooling_present;
      logic laser_present;
   } cfg_type;

   typedef struct packed {
      logic               rd;
      logic [7:0]         opcode;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] index;
   } req_type;

endpackage

`default_nettype wire

### hdl/scr_regs.sv
// Command register file with opcode decode, read mux and write update.
`default_nettype none

module scr_regs (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire scr_pkg::cfg_type           cfg,
   input  wire scr_pkg::req_type           req,
   output logic [scr_pkg::DATA_W-1:0]      read_data,
   output scr_pkg::status_type             status
);
   import scr_pkg::*;

   logic [DATA_W-1:0]  integ_time_ff,  integ_time_in;
   logic [VALUE_W-1:0] gain_even_ff,   gain_even_in;
   logic [VALUE_W-1:0] gain_odd_ff,    gain_odd_in;
   logic [VALUE_W-1:0] offset_even_ff, offset_even_in;
   logic [VALUE_W-1:0] offset_odd_ff,  offset_odd_in;
   logic               cooler_on_ff,   cooler_on_in;
   logic [SETPT_W-1:0] cooler_setp_ff, cooler_setp_in;
   logic               laser_on_ff,    laser_on_in;
   logic               high_gain_ff,   high_gain_in;

   logic               flag;
   logic [DATA_W-1:0]  integ_req;

   assign flag      = (req.value != '0);
   assign integ_req = {req.index[7:0], req.value};

   always_comb begin
      integ_time_in  = integ_time_ff;
      gain_even_in   = gain_even_ff;
      gain_odd_in    = gain_odd_ff;
      offset_even_in = offset_even_ff;
      offset_odd_in  = offset_odd_ff;
      cooler_on_in   = cooler_on_ff;
      cooler_setp_in = cooler_setp_ff;
      laser_on_in    = laser_on_ff;
      high_gain_in   = high_gain_ff;
      read_data      = '0;
      status         = ST_UNKNOWN;
      if (req.rd == REQ_READ) begin
         unique case (req.opcode)
            OP_RD_INTEG_TIME: begin
               read_data = integ_time_ff;
               status    = ST_OK;
            end
            OP_RD_GAIN_EVEN: begin
               read_data = DATA_W'(gain_even_ff);
               status    = ST_OK;
            end
            OP_RD_OFFSET_EVEN: begin
               read_data = DATA_W'(offset_even_ff);
               status    = ST_OK;
            end
            OP_RD_GAIN_ODD: begin
               if (cfg.model_ingaas) begin
                  read_data = DATA_W'(gain_odd_ff);
                  status    = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_RD_OFFSET_ODD: begin
               if (cfg.model_ingaas) begin
                  read_data = DATA_W'(offset_odd_ff);
                  status    = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_RD_COOLER_ON: begin
               if (cfg.cooling_present) begin
                  read_data = DATA_W'(cooler_on_ff);
                  status    = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_RD_LASER_ON: begin
               if (cfg.laser_present) begin
                  read_data = DATA_W'(laser_on_ff);
                  status    = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_RD_HIGH_GAIN: begin
               if (cfg.model_ingaas) begin
                  read_data = DATA_W'(high_gain_ff);
                  status    = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            default: status = ST_UNKNOWN;
         endcase
      end else begin
         unique case (req.opcode)
            OP_WR_INTEG_TIME: begin
               // A zero integration time is stored as one.
               integ_time_in = (integ_req == '0) ? DATA_W'(1) : integ_req;
               status        = ST_OK;
            end
            OP_WR_GAIN_EVEN: begin
               gain_even_in = req.value;
               status       = ST_OK;
            end
            OP_WR_OFFSET_EVEN: begin
               offset_even_in = req.value;
               status         = ST_OK;
            end
            OP_WR_LASER_ON: begin
               laser_on_in = flag;
               status      = ST_OK;
            end
            OP_WR_ACQUIRE: status = ST_OK;
            OP_WR_GAIN_ODD: begin
               if (cfg.model_ingaas) begin
                  gain_odd_in = req.value;
                  status      = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_WR_OFFSET_ODD: begin
               if (cfg.model_ingaas) begin
                  offset_odd_in = req.value;
                  status        = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_WR_HIGH_GAIN: begin
               if (cfg.model_ingaas) begin
                  high_gain_in = flag;
                  status       = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_WR_COOLER_ON: begin
               if (cfg.cooling_present) begin
                  cooler_on_in = flag;
                  status       = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            OP_WR_COOLER_SETP: begin
               if (cfg.cooling_present) begin
                  cooler_setp_in = req.value[SETPT_W-1:0];
                  status         = ST_OK;
               end else begin
                  status = ST_UNSUPPORTED;
               end
            end
            default: status = ST_UNKNOWN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_time_ff  <= DATA_W'(1);
         gain_even_ff   <= GAIN_RESET;
         gain_odd_ff    <= GAIN_RESET;
         offset_even_ff <= '0;
         offset_odd_ff  <= '0;
         cooler_on_ff   <= 1'b0;
         cooler_setp_ff <= '0;
         laser_on_ff    <= 1'b0;
         high_gain_ff   <= 1'b0;
      end else if (fire) begin
         integ_time_ff  <= integ_time_in;
         gain_even_ff   <= gain_even_in;
         gain_odd_ff    <= gain_odd_in;
         offset_even_ff <= offset_even_in;
         offset_odd_ff  <= offset_odd_in;
         cooler_on_ff   <= cooler_on_in;
         cooler_setp_ff <= cooler_setp_in;
         laser_on_ff    <= laser_on_in;
         high_gain_ff   <= high_gain_in;
      end
   end

endmodule

`default_nettype wire

### hdl/spectrometer_command_registers_core.sv
// Top level of the spectrometer command register block.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_stall  req_type, req_opcode, req_value, req_index
//   rsp      out        rsp_valid/rsp_stall  rsp_read_data, rsp_status
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Each access passes through an input register, then the opcode decode and register
// update, then the result register. One access is taken every cycle while rsp is not
// stalled. A stall on rsp holds the result register and then the input register before
// req is stalled. Reset clears the valid flags, the configuration bits and returns every
// command register to its default.
`default_nettype none

module spectrometer_command_registers_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [7:0]                    req_opcode,
   input  wire logic [scr_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [scr_pkg::VALUE_W-1:0]   req_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [scr_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [1:0]                         rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic                          csr_wdata
);
   import scr_pkg::*;

   `include "assert_macros.svh"

   cfg_type           cfg_ff, cfg_in;
   logic              s1_valid_ff, s1_valid_in;
   scr_pkg::req_type  s1_req_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   status_type        rsp_status_ff;
   logic              rsp_open;
   logic              fire;
   logic              req_take;
   logic [DATA_W-1:0] dec_data;
   status_type        dec_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODEL_INGAAS:    cfg_in.model_ingaas    = csr_wdata;
            CSR_COOLING_PRESENT: cfg_in.cooling_present = csr_wdata;
            CSR_LASER_PRESENT:   cfg_in.laser_present   = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   assign rsp_open     = !rsp_valid_ff || !rsp_stall;
   assign fire         = s1_valid_ff && rsp_open;
   assign req_stall    = s1_valid_ff && !rsp_open;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   scr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .cfg       (cfg_ff),
      .req       (s1_req_ff),
      .read_data (dec_data),
      .status    (dec_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= '{rd: req_type, opcode: req_opcode, value: req_value, index: req_index};
      end
      if (fire) begin
         rsp_data_ff   <= dec_data;
         rsp_status_ff <= dec_status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   `ASSERT_CLKD(a_err_no_data, clock, reset,
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == '0), "failed access carries data")
   `ASSERT_CLKD(a_rsp_drains, clock, reset,
      (rsp_valid && !rsp_stall && !fire) |=> !rsp_valid, "result repeated after transfer")
   `ASSERT_CLKD(a_req_held, clock, reset,
      (req_valid && !req_stall) |=> s1_valid_ff, "accepted access lost")
   `ASSERT_ALWAYS(a_reset_idle, clock,
      $past(reset) |-> (!rsp_valid && !req_stall), "block not idle after reset")

endmodule

`default_nettype wire
